// ----- sv/wma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_pkg
// Shared widths, reset values and control types of the moving average unit.
// ----------------------------------------------------------------------------
package wma_pkg;

    // Field widths of the channels and of the configuration register.
    localparam int SAMPLE_W = 32;
    localparam int LEN_W    = 7;
    localparam int OUT_W    = 40;

    // Configuration port geometry.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // Register index of the window length and its value after reset.
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = 7'd5;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;     // input channel may accept a word
        logic sum;      // form the window sum and update the window state
        logic fill;     // write one ring entry of the priming sweep
        logic prep;     // load the divider from the window sum
        logic step;     // one restoring divide step
        logic finish;   // load the output register
    } wma_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;   // an input word is offered
        logic len_zero;   // effective window length is zero
        logic fill_req;   // this item primes the window
        logic fill_last;  // last entry of the priming sweep
        logic div_last;   // last divide step
        logic out_free;   // output register can take a result
    } wma_status_t;

endpackage

// ----- sv/wma_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_in_if
// Input channel: one price sample and its commit flag per word.
// ----------------------------------------------------------------------------
interface wma_in_if
    import wma_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       commit;

    modport source (output valid, output sample, output commit, input ready);
    modport sink   (input valid, input sample, input commit, output ready);
endinterface

// ----- sv/wma_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_out_if
// Output channel: one window mean per word.
// ----------------------------------------------------------------------------
interface wma_out_if
    import wma_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] average;

    modport source (output valid, output average, input ready);
    modport sink   (input valid, input average, output ready);
endinterface

// ----- sv/wma_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_ctrl
// Sequencer of the moving average unit: steps one item through sum, optional
// priming sweep, serial divide unless the length is zero, and output load.
// ----------------------------------------------------------------------------
module wma_ctrl
    import wma_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  wma_status_t status,
    output wma_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_FILL,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (status.in_valid)
                    state_next = ST_SUM;
            end
            ST_SUM:
            begin
                priority if (status.len_zero)
                    state_next = ST_DONE;
                else if (status.fill_req)
                    state_next = ST_FILL;
                else
                    state_next = ST_PREP;
            end
            ST_FILL:
            begin
                if (status.fill_last)
                    state_next = ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Command decode.
    always_comb
    begin
        cmd        = '0;
        cmd.take   = (state_reg == ST_IDLE);
        cmd.sum    = (state_reg == ST_SUM);
        cmd.fill   = (state_reg == ST_FILL);
        cmd.prep   = (state_reg == ST_PREP);
        cmd.step   = (state_reg == ST_DIV);
        cmd.finish = (state_reg == ST_DONE) && status.out_free;
    end

endmodule

// ----- sv/wma_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wma_datapath
// Sample ring, running sum, window pointer, radix-2 divider and the output
// register of the moving average unit.
// ----------------------------------------------------------------------------
module wma_datapath
    import wma_pkg::*;
#(
    parameter int MAX_WINDOW    = 64,
    parameter int FRACTION_BITS = 8
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [LEN_W-1:0] window_length,
    input  logic             clear,
    input  wma_cmd_t         cmd,
    output wma_status_t      status,
    wma_in_if.sink           sample_ch,
    wma_out_if.source        average_ch
);

    // The register field cannot name more than its own range of lengths.
    localparam int LEN_LIMIT = (1 << LEN_W) - 1;
    localparam int LEN_MAX   = (MAX_WINDOW > LEN_LIMIT) ? LEN_LIMIT : MAX_WINDOW;
    localparam int PTR_W     = (LEN_MAX > 1) ? $clog2(LEN_MAX) : 1;
    localparam int SUM_W     = SAMPLE_W + $clog2(LEN_MAX);
    localparam int DIV_W     = SUM_W + FRACTION_BITS;
    localparam int CNT_W     = $clog2(DIV_W + 1);
    localparam int WIDE_W    = 64;

    // Sample ring.
    logic [SAMPLE_W-1:0] ring [LEN_MAX];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                ring_we;
    logic [PTR_W-1:0]    ring_waddr;

    // Window state.
    logic signed [SUM_W-1:0] running_sum_reg;
    logic [PTR_W-1:0]        ptr_reg;
    logic                    primed_reg;

    // Captured item.
    logic signed [SAMPLE_W-1:0] sample_reg;
    logic                       commit_reg;
    logic [LEN_W-1:0]           len_reg;
    logic                       zero_reg;

    // Sum and priming sweep.
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [LEN_W-1:0]        fill_cnt_reg;

    // Divider.
    logic [DIV_W-1:0] dq_reg;
    logic [LEN_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             neg_reg;

    // Output register.
    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] average_reg;

    logic load;
    logic [LEN_W-1:0] eff_len;

    assign load = sample_ch.valid && cmd.take;
    assign sample_ch.ready = cmd.take;

    // Effective window length saturates at the ring depth.
    assign eff_len = (32'(window_length) > LEN_MAX) ? LEN_W'(LEN_MAX) : window_length;

    // Window sum: L copies of the sample for an empty window, else slide.
    logic signed [SAMPLE_W+LEN_W:0] prod;
    assign prod = sample_reg * $signed({1'b0, len_reg});

    always_comb
    begin
        if (primed_reg)
            sum_next = running_sum_reg + sample_reg - $signed(rd_data_reg);
        else
            sum_next = prod[SUM_W-1:0];
    end

    // Pointer advance with wrap at the window length.
    logic [LEN_W:0]   ptr_inc;
    logic [PTR_W-1:0] ptr_adv;
    assign ptr_inc = (LEN_W + 1)'(ptr_reg) + 1'b1;
    assign ptr_adv = (ptr_inc >= {1'b0, len_reg}) ? '0 : PTR_W'(ptr_inc);

    // Ring write port: single slot on a slide, sweep while priming.
    assign ring_we    = (cmd.sum && commit_reg && primed_reg && !zero_reg) || cmd.fill;
    assign ring_waddr = cmd.fill ? fill_cnt_reg[PTR_W-1:0] : ptr_reg;

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring[ring_waddr] <= sample_reg;
        if (load)
            rd_data_reg <= ring[ptr_reg];
    end

    // Item capture.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sample_reg <= sample_ch.sample;
            commit_reg <= sample_ch.commit;
            len_reg    <= eff_len;
            zero_reg   <= (eff_len == '0);
        end
    end

    // Window state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            ptr_reg         <= '0;
            primed_reg      <= 1'b0;
        end
        else if (clear)
        begin
            running_sum_reg <= '0;
            ptr_reg         <= '0;
            primed_reg      <= 1'b0;
        end
        else if (cmd.sum && commit_reg && !zero_reg)
        begin
            running_sum_reg <= sum_next;
            primed_reg      <= 1'b1;
            ptr_reg         <= primed_reg ? ptr_adv : '0;
        end
    end

    // Sum register and priming sweep counter.
    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            sum_reg      <= sum_next;
            fill_cnt_reg <= '0;
        end
        else if (cmd.fill)
        begin
            fill_cnt_reg <= fill_cnt_reg + 1'b1;
        end
    end

    // Restoring divider on the magnitude of sum * 2^FRACTION_BITS.
    logic [SUM_W-1:0] sum_mag;
    logic [LEN_W:0]   shifted;
    logic             q_bit;
    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign shifted = {rem_reg, dq_reg[DIV_W-1]};
    assign q_bit   = (shifted >= {1'b0, len_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            dq_reg  <= DIV_W'(sum_mag) << FRACTION_BITS;
            rem_reg <= '0;
            cnt_reg <= '0;
            neg_reg <= sum_reg[SUM_W-1];
        end
        else if (cmd.step)
        begin
            dq_reg  <= {dq_reg[DIV_W-2:0], q_bit};
            rem_reg <= q_bit ? LEN_W'(shifted - {1'b0, len_reg}) : shifted[LEN_W-1:0];
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Signed result, sign-extended and cut to the output width.
    logic signed [DIV_W:0]    q_signed;
    logic signed [WIDE_W-1:0] q_wide;
    assign q_signed = neg_reg ? -$signed({1'b0, dq_reg}) : $signed({1'b0, dq_reg});
    assign q_wide   = WIDE_W'(q_signed);

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (average_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
            average_reg <= zero_reg ? '0 : q_wide[OUT_W-1:0];
    end

    assign average_ch.valid   = out_valid_reg;
    assign average_ch.average = average_reg;

    // Status to the controller.
    always_comb
    begin
        status           = '0;
        status.in_valid  = sample_ch.valid;
        status.len_zero  = zero_reg;
        status.fill_req  = commit_reg && !primed_reg && !zero_reg;
        status.fill_last = (fill_cnt_reg == LEN_W'(len_reg - 1'b1));
        status.div_last  = (cnt_reg == CNT_W'(DIV_W - 1));
        status.out_free  = !out_valid_reg || average_ch.ready;
    end

endmodule

// ----- sv/windowed_moving_average_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_moving_average_unit
// Simple moving average over a ring of recent price samples.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch carries a signed 32-bit sample and a commit flag per word.
//   With commit set the sample enters the window and the oldest leaves;
//   with commit clear the mean is as with commit set, but no window state changes.
//   average_ch returns one signed 40-bit mean per word, with FRACTION_BITS
//   fraction bits, truncated toward zero.
//   The APB port holds the window length at address 0; writing it empties
//   the window. The first committed sample then fills the whole window.
// Sequence:
//   A word is taken only while the unit is idle; each item is summed,
//   divided and loaded into the output register before the next word is
//   taken. The serial divider takes one quotient bit per cycle for a
//   quotient of DIV_W = 32 + log2(window depth) + FRACTION_BITS bits.
//   A committed sample into an empty window first runs the ring fill over
//   every window entry. A zero window length answers 0 without a divide.
// Reset and stall:
//   Reset empties the window and sets the length to 5. A stalled receiver
//   holds the result in the output register; the next item waits until it
//   can be loaded.
// ----------------------------------------------------------------------------
module windowed_moving_average_unit
    import wma_pkg::*;
#(
    parameter int MAX_WINDOW    = 64,
    parameter int FRACTION_BITS = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    wma_in_if.sink                sample_ch,
    wma_out_if.source             average_ch
);

    logic [LEN_W-1:0] window_length_reg;
    logic             cfg_write;
    logic             hit_length;
    wma_cmd_t         cmd;
    wma_status_t      status;

    // Register decode: paddr[2] selects the word; only word 0 holds a register, the 7-bit window length.
    assign pready     = 1'b1;
    assign hit_length = (paddr[2] == REG_WINDOW_LENGTH);
    assign cfg_write  = psel && penable && pwrite && pready && hit_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            window_length_reg <= WINDOW_LENGTH_RESET;
        else if (cfg_write)
            window_length_reg <= pwdata[LEN_W-1:0];
    end

    assign prdata = hit_length ? APB_DATA_W'(window_length_reg) : '0;

    wma_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    wma_datapath #(
        .MAX_WINDOW    (MAX_WINDOW),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .window_length (window_length_reg),
        .clear         (cfg_write),
        .cmd           (cmd),
        .status        (status),
        .sample_ch     (sample_ch),
        .average_ch    (average_ch)
    );

endmodule
